// ----- sv/fqu_pkg.sv -----
package fqu_pkg;

    // default sizing
    localparam int DEPTH_DEF    = 16;
    localparam int ID_WIDTH_DEF = 16;

    // fixed field widths
    localparam int IN_ID_W   = 16;
    localparam int WEIGHT_W  = 20;
    localparam int DEST_W    = 16;
    localparam int OUT_ID_W  = 16;
    localparam int TDATA_W   = 56;

    // request operation
    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    // result status
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_DUP   = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CMP,
        S_DEQ_WAIT,
        S_FINISH
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    accept;
        logic    mem_read_scan;
        logic    mem_read_deq;
        logic    scan_step;
        logic    write_entry;
        logic    deq_pop;
        logic    set_status;
        status_t code;
        logic    publish;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        op_t  req_op;
        logic occ_zero;
        logic full;
        logic scan_done;
        logic id_match;
        logic out_free;
    } stat_t;

endpackage

// ----- sv/fqu_ctrl.sv -----
module fqu_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  fqu_pkg::stat_t stat,
    output fqu_pkg::cmd_t  cmd
);

    fqu_pkg::state_t state_reg;
    fqu_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fqu_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fqu_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fqu_pkg::S_CHECK;
                end
            end
            fqu_pkg::S_CHECK:
            begin
                if (stat.req_op == fqu_pkg::OP_DEQ)
                begin
                    state_next = stat.occ_zero ? fqu_pkg::S_FINISH : fqu_pkg::S_DEQ_WAIT;
                end
                else
                begin
                    state_next = stat.scan_done ? fqu_pkg::S_FINISH : fqu_pkg::S_CMP;
                end
            end
            fqu_pkg::S_CMP:
            begin
                state_next = stat.id_match ? fqu_pkg::S_FINISH : fqu_pkg::S_CHECK;
            end
            fqu_pkg::S_DEQ_WAIT:
            begin
                state_next = fqu_pkg::S_FINISH;
            end
            fqu_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = fqu_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fqu_pkg::S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        cmd.code = fqu_pkg::STAT_OK;
        case (state_reg)
            fqu_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            fqu_pkg::S_CHECK:
            begin
                if (stat.req_op == fqu_pkg::OP_DEQ)
                begin
                    if (stat.occ_zero)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.code       = fqu_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        cmd.mem_read_deq = 1'b1;
                    end
                end
                else if (stat.scan_done)
                begin
                    if (stat.full)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.code       = fqu_pkg::STAT_FULL;
                    end
                    else
                    begin
                        cmd.write_entry = 1'b1;
                    end
                end
                else
                begin
                    cmd.mem_read_scan = 1'b1;
                end
            end
            fqu_pkg::S_CMP:
            begin
                if (stat.id_match)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = fqu_pkg::STAT_DUP;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            fqu_pkg::S_DEQ_WAIT:
            begin
                cmd.deq_pop = 1'b1;
            end
            fqu_pkg::S_FINISH:
            begin
                cmd.publish = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/fqu_datapath.sv -----
module fqu_datapath
#(
    parameter int DEPTH    = fqu_pkg::DEPTH_DEF,
    parameter int ID_WIDTH = fqu_pkg::ID_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  fqu_pkg::cmd_t                 cmd,
    output fqu_pkg::stat_t                stat,
    input  logic                          in_op,
    input  logic [fqu_pkg::IN_ID_W-1:0]   in_id,
    input  logic [fqu_pkg::WEIGHT_W-1:0]  in_weight,
    input  logic [fqu_pkg::DEST_W-1:0]    in_dest,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    out_status,
    output logic [fqu_pkg::OUT_ID_W-1:0]  out_id,
    output logic [fqu_pkg::WEIGHT_W-1:0]  out_weight,
    output logic [fqu_pkg::DEST_W-1:0]    out_dest
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (ID_WIDTH > fqu_pkg::IN_ID_W) ? ID_WIDTH : fqu_pkg::IN_ID_W;

    // entry storage
    logic [ID_WIDTH-1:0]          id_mem     [DEPTH];
    logic [fqu_pkg::WEIGHT_W-1:0] weight_mem [DEPTH];
    logic [fqu_pkg::DEST_W-1:0]   dest_mem   [DEPTH];

    // queue control
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [CNT_W-1:0] occ_reg;
    logic [PTR_W-1:0] scan_ptr_reg;
    logic [CNT_W-1:0] scan_cnt_reg;
    logic             out_valid_reg;

    // request and read data
    fqu_pkg::op_t                 req_op_reg;
    logic [ID_WIDTH-1:0]          req_id_reg;
    logic [fqu_pkg::WEIGHT_W-1:0] req_weight_reg;
    logic [fqu_pkg::DEST_W-1:0]   req_dest_reg;
    logic [ID_WIDTH-1:0]          rd_id_reg;
    logic [fqu_pkg::WEIGHT_W-1:0] rd_weight_reg;
    logic [fqu_pkg::DEST_W-1:0]   rd_dest_reg;

    // pending result and output register
    fqu_pkg::status_t             res_status_reg;
    logic [fqu_pkg::OUT_ID_W-1:0] res_id_reg;
    logic [fqu_pkg::WEIGHT_W-1:0] res_weight_reg;
    logic [fqu_pkg::DEST_W-1:0]   res_dest_reg;
    fqu_pkg::status_t             out_status_reg;
    logic [fqu_pkg::OUT_ID_W-1:0] out_id_reg;
    logic [fqu_pkg::WEIGHT_W-1:0] out_weight_reg;
    logic [fqu_pkg::DEST_W-1:0]   out_dest_reg;

    logic [EXT_W-1:0] in_id_ext;
    logic [EXT_W-1:0] rd_id_ext;
    logic [PTR_W-1:0] rd_addr;
    logic [PTR_W-1:0] rd_ptr_adv;
    logic [PTR_W-1:0] wr_ptr_adv;
    logic [PTR_W-1:0] scan_ptr_adv;

    // key is the low ID_WIDTH bits of the request id
    assign in_id_ext = EXT_W'(in_id);
    assign rd_id_ext = EXT_W'(rd_id_reg);

    assign rd_addr = cmd.mem_read_deq ? rd_ptr_reg : scan_ptr_reg;

    // ring pointer wrap
    assign rd_ptr_adv   = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_ptr_adv   = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign scan_ptr_adv = (scan_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : scan_ptr_reg + 1'b1;

    // storage write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.write_entry)
        begin
            id_mem[wr_ptr_reg]     <= req_id_reg;
            weight_mem[wr_ptr_reg] <= req_weight_reg;
            dest_mem[wr_ptr_reg]   <= req_dest_reg;
        end
        if (cmd.mem_read_scan || cmd.mem_read_deq)
        begin
            rd_id_reg     <= id_mem[rd_addr];
            rd_weight_reg <= weight_mem[rd_addr];
            rd_dest_reg   <= dest_mem[rd_addr];
        end
    end

    // queue control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            occ_reg       <= '0;
            scan_ptr_reg  <= '0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                scan_ptr_reg <= rd_ptr_reg;
                scan_cnt_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                scan_ptr_reg <= scan_ptr_adv;
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if (cmd.write_entry)
            begin
                wr_ptr_reg <= wr_ptr_adv;
                occ_reg    <= occ_reg + 1'b1;
            end
            else if (cmd.deq_pop)
            begin
                rd_ptr_reg <= rd_ptr_adv;
                occ_reg    <= occ_reg - 1'b1;
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // capture request, build result, load output
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_op_reg     <= fqu_pkg::op_t'(in_op);
            req_id_reg     <= in_id_ext[ID_WIDTH-1:0];
            req_weight_reg <= in_weight;
            req_dest_reg   <= in_dest;
        end
        if (cmd.set_status || cmd.write_entry)
        begin
            res_status_reg <= cmd.set_status ? cmd.code : fqu_pkg::STAT_OK;
            res_id_reg     <= '0;
            res_weight_reg <= '0;
            res_dest_reg   <= '0;
        end
        else if (cmd.deq_pop)
        begin
            res_status_reg <= fqu_pkg::STAT_OK;
            res_id_reg     <= rd_id_ext[fqu_pkg::OUT_ID_W-1:0];
            res_weight_reg <= rd_weight_reg;
            res_dest_reg   <= rd_dest_reg;
        end
        if (cmd.publish)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_weight_reg <= res_weight_reg;
            out_dest_reg   <= res_dest_reg;
        end
    end

    // status to controller
    always_comb
    begin
        stat.req_op    = req_op_reg;
        stat.occ_zero  = (occ_reg == '0);
        stat.full      = (occ_reg == CNT_W'(DEPTH));
        stat.scan_done = (scan_cnt_reg == occ_reg);
        stat.id_match  = (rd_id_reg == req_id_reg);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_id     = out_id_reg;
    assign out_weight = out_weight_reg;
    assign out_dest   = out_dest_reg;

endmodule

// ----- sv/fifo_queue_unique_key.sv -----
// Bounded first-in first-out order queue with unique identifiers. Each request
// on the slave stream is an enqueue or a dequeue and yields exactly one result
// on the master stream: status ok, duplicate, empty or full, plus the dequeued
// order's fields (zero on every other result). An enqueue is checked against
// every occupied entry by walking the identifier memory through its single
// read port, one entry at a time in the check and compare states, stopping
// early when a duplicate is found. A dequeue reads the head entry and then
// pops it; on an empty queue it goes straight to the finish state. A new
// request is taken while a finished result still waits on the master side.
// Entry storage needs no clearing after reset.
module fifo_queue_unique_key
#(
    parameter int DEPTH    = fqu_pkg::DEPTH_DEF,
    parameter int ID_WIDTH = fqu_pkg::ID_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [fqu_pkg::TDATA_W-1:0]  s_axis_tdata,  // item_id, weight_grams, dest_code
    input  logic [0:0]                   s_axis_tuser,  // op
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [fqu_pkg::TDATA_W-1:0]  m_axis_tdata,  // out_id, out_weight, out_dest
    output logic [1:0]                   m_axis_tuser   // status
);

    fqu_pkg::cmd_t  cmd;
    fqu_pkg::stat_t stat;

    logic [fqu_pkg::OUT_ID_W-1:0] out_id;
    logic [fqu_pkg::WEIGHT_W-1:0] out_weight;
    logic [fqu_pkg::DEST_W-1:0]   out_dest;

    // sequencing
    fqu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage, pointers and result registers
    fqu_datapath
    #(
        .DEPTH    (DEPTH),
        .ID_WIDTH (ID_WIDTH)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_axis_tuser[0]),
        .in_id      (s_axis_tdata[15:0]),
        .in_weight  (s_axis_tdata[35:16]),
        .in_dest    (s_axis_tdata[51:36]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_id     (out_id),
        .out_weight (out_weight),
        .out_dest   (out_dest)
    );

    // pack result fields, pad to whole bytes
    assign m_axis_tdata = {4'b0000, out_dest, out_weight, out_id};

endmodule

// ----- dv/fifo_queue_unique_key_test.sv -----
module fifo_queue_unique_key_test;
    import fqu_pkg::*;

    localparam int QDEPTH      = DEPTH_DEF;
    localparam int ID_W        = ID_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;

    // one expected queue result
    typedef struct {
        status_t               status;
        logic [OUT_ID_W-1:0]   id;
        logic [WEIGHT_W-1:0]   weight;
        logic [DEST_W-1:0]     dest;
    } order_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata = '0;   // item_id, weight_grams, dest_code
    logic [0:0]            s_axis_tuser = '0;   // op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;        // out_id, out_weight, out_dest
    logic [1:0]            m_axis_tuser;        // status

    // shadow of the order queue
    logic [ID_W-1:0]       shadow_id     [QDEPTH];
    logic [WEIGHT_W-1:0]   shadow_weight [QDEPTH];
    logic [DEST_W-1:0]     shadow_dest   [QDEPTH];
    int                    shadow_rd = 0;
    int                    shadow_wr = 0;
    int                    shadow_count = 0;

    order_result_t         pending_results[$];
    int                    err_count = 0;
    int                    cycle_count = 0;
    int                    rx_hold = 0;
    bit                    tx_idle_en = 1'b1;
    bit                    rx_idle_en = 1'b1;

    fifo_queue_unique_key dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // apply one request to the shadow queue and return its result
    function automatic order_result_t predict_order_result(input op_t op,
                                                           input logic [IN_ID_W-1:0] id,
                                                           input logic [WEIGHT_W-1:0] wt,
                                                           input logic [DEST_W-1:0] dst);
        order_result_t r;
        logic [ID_W-1:0] key;
        bit hit;
        r.status = STAT_OK;
        r.id     = '0;
        r.weight = '0;
        r.dest   = '0;
        key      = id[ID_W-1:0];
        hit      = 1'b0;
        if (op == OP_ENQ)
        begin
            for (int n = 0; n < shadow_count; n++)
            begin
                if (shadow_id[(shadow_rd + n) % QDEPTH] == key)
                    hit = 1'b1;
            end
            // duplicate check wins over full
            if (hit)
                r.status = STAT_DUP;
            else if (shadow_count >= QDEPTH)
                r.status = STAT_FULL;
            else
            begin
                shadow_id[shadow_wr]     = key;
                shadow_weight[shadow_wr] = wt;
                shadow_dest[shadow_wr]   = dst;
                shadow_wr                = (shadow_wr + 1) % QDEPTH;
                shadow_count++;
            end
        end
        else if (shadow_count == 0)
            r.status = STAT_EMPTY;
        else
        begin
            r.id         = OUT_ID_W'(shadow_id[shadow_rd]);
            r.weight     = shadow_weight[shadow_rd];
            r.dest       = shadow_dest[shadow_rd];
            shadow_rd    = (shadow_rd + 1) % QDEPTH;
            shadow_count--;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at cycle %0d: got %0h, want %0h",
                 field, cycle_count, got, want);
        err_count++;
    endtask

    // present one request and hold it until it is taken
    task automatic send_request(input op_t op, input logic [IN_ID_W-1:0] id,
                                input logic [WEIGHT_W-1:0] wt, input logic [DEST_W-1:0] dst);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0000, dst, wt, id};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(predict_order_result(op, id, wt, dst));
    endtask

    // stop sending until every result is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // one random request; enqueues often reuse live or pooled identifiers
    task automatic send_random_request(input int enq_pct);
        op_t op;
        logic [IN_ID_W-1:0] id;
        int pick;
        op   = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        id   = IN_ID_W'($urandom);
        pick = $urandom_range(0, 3);
        if (op == OP_ENQ && pick == 0 && shadow_count > 0)
            id = IN_ID_W'(shadow_id[(shadow_rd + $urandom_range(0, shadow_count - 1)) % QDEPTH]);
        else if (op == OP_ENQ && pick == 1)
            id = 16'h5A00 | IN_ID_W'($urandom_range(0, 23));
        send_request(op, id, WEIGHT_W'($urandom), DEST_W'($urandom));
    endtask

    task automatic test_empty_dequeue();
        send_request(OP_DEQ, 16'hFFFF, 20'hFFFFF, 16'hFFFF);
    endtask

    task automatic test_field_extremes();
        send_request(OP_ENQ, 16'h0000, 20'h00000, 16'h0000);
        send_request(OP_ENQ, 16'hFFFF, 20'hFFFFF, 16'hFFFF);
        // same identifier, other payload
        send_request(OP_ENQ, 16'hFFFF, 20'h12345, 16'h0F0F);
    endtask

    task automatic test_fill_to_full();
        for (int i = 0; i < QDEPTH - 2; i++)
            send_request(OP_ENQ, 16'h1000 + IN_ID_W'(i) * 16'h0111,
                         WEIGHT_W'($urandom), DEST_W'($urandom));
        send_request(OP_ENQ, 16'h7777, 20'hABCDE, 16'h3C3C);
        // duplicate while full
        send_request(OP_ENQ, 16'h0000, 20'h00001, 16'h0001);
    endtask

    task automatic test_dequeue_order();
        repeat (3)
            send_request(OP_DEQ, IN_ID_W'($urandom), WEIGHT_W'($urandom), DEST_W'($urandom));
        wait_drained();
    endtask

    // phases of enqueue-heavy, balanced and dequeue-heavy traffic
    task automatic test_random_traffic(input int n_items);
        int sent;
        int phase_len;
        int enq_pct;
        sent = 0;
        while (sent < n_items)
        begin
            phase_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0:       enq_pct = 90;
                1:       enq_pct = 50;
                default: enq_pct = 12;
            endcase
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
                wait_drained();
            for (int i = 0; i < phase_len && sent < n_items; i++)
            begin
                send_random_request(enq_pct);
                sent++;
            end
        end
    endtask

    task automatic test_back_to_back(input int n_items);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int i = 0; i < n_items; i++)
            send_random_request(((i / 40) % 2 == 0) ? 80 : 25);
    endtask

    // randomly stall the result side in bursts
    always @(posedge clk)
    begin
        if (rx_hold != 0)
            rx_hold <= rx_hold - 1;
        else if (rx_idle_en && $urandom_range(0, 3) == 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold       <= $urandom_range(0, 9);
        end
        else
        begin
            m_axis_tready <= 1'b1;
            rx_hold       <= $urandom_range(0, 9);
        end
    end

    // compare each taken result with the oldest expectation
    always @(posedge clk)
    begin : check_result
        order_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 32'(m_axis_tuser), 32'(0));
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                if (m_axis_tdata[15:0] !== want.id)
                    report_mismatch("out_id", 32'(m_axis_tdata[15:0]), 32'(want.id));
                if (m_axis_tdata[35:16] !== want.weight)
                    report_mismatch("out_weight", 32'(m_axis_tdata[35:16]), 32'(want.weight));
                if (m_axis_tdata[51:36] !== want.dest)
                    report_mismatch("out_dest", 32'(m_axis_tdata[51:36]), 32'(want.dest));
                if (m_axis_tdata[55:52] !== 4'b0000)
                    report_mismatch("tdata padding", 32'(m_axis_tdata[55:52]), 32'(0));
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_dequeue();
        test_field_extremes();
        test_fill_to_full();
        test_dequeue_order();
        test_random_traffic(1600);
        test_back_to_back(300);

        // let the last results drain
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
sv/fqu_pkg.sv
sv/fqu_ctrl.sv
sv/fqu_datapath.sv
sv/fifo_queue_unique_key.sv
dv/fifo_queue_unique_key_test.sv
